FILE: rtl/integer_to_decimal_text_assert.svh
// Assertion macros for the decimal text converter.
`ifndef INTEGER_TO_DECIMAL_TEXT_ASSERT_SVH
`define INTEGER_TO_DECIMAL_TEXT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// a implies b in the same cycle
`define I2DT_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: a |-> b");

// a implies b in the next cycle
`define I2DT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: a |=> b");

`else

`define I2DT_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define I2DT_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

FILE: rtl/i2dt_pkg.sv
`default_nettype none

package i2dt_pkg;

    localparam int VALUE_BITS  = 128;
    localparam int MAX_CHARS   = 40;
    localparam int DIGIT_SLOTS = 39;

    localparam int BCD_W     = DIGIT_SLOTS * 4;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int CHR_CNT_W = $clog2(MAX_CHARS + 1);

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_STRIP,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

    // conversion request from the input side
    typedef struct packed {
        logic                  start;
        logic                  negative;
        logic [VALUE_BITS-1:0] magnitude;
    } job_t;

    // finished digits, least significant digit in the low nibble
    typedef struct packed {
        logic             load;
        logic             negative;
        logic [BCD_W-1:0] digits;
    } bcd_t;

endpackage

`default_nettype wire

FILE: rtl/i2dt_dabble.sv
`default_nettype none

module i2dt_dabble (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire i2dt_pkg::job_t job,
    output i2dt_pkg::bcd_t     result,
    output logic               busy
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [i2dt_pkg::BIT_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [i2dt_pkg::VALUE_BITS-1:0]     mag_reg, mag_next;
    logic [i2dt_pkg::BCD_W-1:0]          bcd_reg, bcd_next;
    logic [i2dt_pkg::BCD_W-1:0]          bcd_adj;
    logic                                neg_reg, neg_next;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2dt_pkg::DIGIT_SLOTS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        if (job.start)
        begin
            busy_next = 1'b1;
            cnt_next  = i2dt_pkg::BIT_CNT_W'(i2dt_pkg::VALUE_BITS - 1);
            mag_next  = job.magnitude;
            bcd_next  = '0;
            neg_next  = job.negative;
        end
        else if (busy_reg)
        begin
            // shift in one magnitude bit, msb first
            bcd_next = {bcd_adj[i2dt_pkg::BCD_W-2:0], mag_reg[i2dt_pkg::VALUE_BITS-1]};
            mag_next = {mag_reg[i2dt_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign result.load     = done_reg;
    assign result.negative = neg_reg;
    assign result.digits   = bcd_reg;
    assign busy            = busy_reg | done_reg;

endmodule

`default_nettype wire

FILE: rtl/i2dt_emit.sv
`default_nettype none

module i2dt_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire i2dt_pkg::bcd_t result,
    output logic               busy,
    output logic               text_valid,
    input  wire logic          text_ready,
    output logic [5:0]         character,
    output logic               last_char
);

    i2dt_pkg::emit_state_t               state_reg, state_next;
    logic [i2dt_pkg::BCD_W-1:0]          digits_reg, digits_next;
    logic [i2dt_pkg::DIG_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [i2dt_pkg::CHR_CNT_W-1:0]      sent_reg, sent_next;
    logic                                neg_reg, neg_next;
    logic                                valid_reg, valid_next;
    logic [5:0]                          char_reg, char_next;
    logic                                last_reg, last_next;
    logic                                slot_free;
    logic [3:0]                          top_digit;
    logic                                word_last;

    assign slot_free = !valid_reg || text_ready;
    assign top_digit = digits_reg[i2dt_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        sent_next   = sent_reg;
        neg_next    = neg_reg;
        valid_next  = valid_reg && !text_ready;
        char_next   = char_reg;
        last_next   = last_reg;
        word_last   = 1'b0;
        unique case (state_reg)
            i2dt_pkg::EMIT_IDLE:
            begin
                if (result.load)
                begin
                    digits_next = result.digits;
                    neg_next    = result.negative;
                    cnt_next    = i2dt_pkg::DIG_CNT_W'(i2dt_pkg::DIGIT_SLOTS);
                    state_next  = i2dt_pkg::EMIT_STRIP;
                end
            end
            i2dt_pkg::EMIT_STRIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && cnt_reg != i2dt_pkg::DIG_CNT_W'(1))
                begin
                    digits_next = {digits_reg[i2dt_pkg::BCD_W-5:0], 4'd0};
                    cnt_next    = cnt_reg - 1'b1;
                end
                else
                begin
                    sent_next  = '0;
                    state_next = neg_reg ? i2dt_pkg::EMIT_SIGN : i2dt_pkg::EMIT_DIGIT;
                end
            end
            i2dt_pkg::EMIT_SIGN:
            begin
                if (slot_free)
                begin
                    word_last  = (i2dt_pkg::MAX_CHARS == 1);
                    valid_next = 1'b1;
                    char_next  = i2dt_pkg::ASCII_MINUS;
                    last_next  = word_last;
                    sent_next  = sent_reg + 1'b1;
                    state_next = word_last ? i2dt_pkg::EMIT_IDLE : i2dt_pkg::EMIT_DIGIT;
                end
            end
            i2dt_pkg::EMIT_DIGIT:
            begin
                if (slot_free)
                begin
                    word_last = (cnt_reg == i2dt_pkg::DIG_CNT_W'(1)) ||
                                (sent_reg == i2dt_pkg::CHR_CNT_W'(i2dt_pkg::MAX_CHARS - 1));
                    valid_next  = 1'b1;
                    char_next   = i2dt_pkg::ASCII_ZERO + {2'b00, top_digit};
                    last_next   = word_last;
                    digits_next = {digits_reg[i2dt_pkg::BCD_W-5:0], 4'd0};
                    cnt_next    = cnt_reg - 1'b1;
                    sent_next   = sent_reg + 1'b1;
                    if (word_last)
                        state_next = i2dt_pkg::EMIT_IDLE;
                end
            end
            default:
            begin
                state_next = i2dt_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2dt_pkg::EMIT_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        sent_reg   <= sent_next;
        neg_reg    <= neg_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign busy       = (state_reg != i2dt_pkg::EMIT_IDLE) || valid_reg;
    assign text_valid = valid_reg;
    assign character  = char_reg;
    assign last_char  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/integer_to_decimal_text.sv
// After a value is accepted, the bit-serial BCD shifter takes in all 128 magnitude bits; then leading
// zeros are dropped (up to 38) before the first character is offered.
// Then one character per cycle while text_ready is high, at most 40 characters per value.
// One value at a time: the next is accepted once the last character of the text is taken.
// Reset (rst_n, asynchronous, active low) clears all control state; no word is pending after.
`default_nettype none

`include "integer_to_decimal_text_assert.svh"

module integer_to_decimal_text (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        value_valid,
    output logic             value_ready,
    input  wire logic [63:0] value_high,
    input  wire logic [63:0] value_low,
    input  wire logic        signed_mode,
    output logic             text_valid,
    input  wire logic        text_ready,
    output logic [5:0]       character,
    output logic             last_char
);

    logic [127:0]                    full_value;
    logic [i2dt_pkg::VALUE_BITS-1:0] raw;
    logic                            negative;
    logic                            dabble_busy;
    logic                            emit_busy;
    i2dt_pkg::job_t                  job;
    i2dt_pkg::bcd_t                  result;

    assign full_value = {value_high, value_low};
    assign raw        = full_value[i2dt_pkg::VALUE_BITS-1:0];
    assign negative   = signed_mode && raw[i2dt_pkg::VALUE_BITS-1];

    assign value_ready   = !dabble_busy && !emit_busy;
    assign job.start     = value_valid && value_ready;
    assign job.negative  = negative;
    assign job.magnitude = negative ? (~raw + 1'b1) : raw;

    i2dt_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job),
        .result (result),
        .busy   (dabble_busy)
    );

    i2dt_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .result     (result),
        .busy       (emit_busy),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .character  (character),
        .last_char  (last_char)
    );

    `I2DT_ASSERT_NOW(a_ready_no_text, clk, rst_n, value_ready, !text_valid)
    `I2DT_ASSERT_NEXT(a_accept_busy, clk, rst_n, value_valid && value_ready, !value_ready)
    `I2DT_ASSERT_NOW(a_minus_not_last, clk, rst_n,
        text_valid && character == i2dt_pkg::ASCII_MINUS, !last_char)

endmodule

`default_nettype wire
